[design/orbit_min_representative_check_top_assert.svh]
// ----------------------------------------------------------------------------
// Orbit minimum check assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ORBIT_MIN_REPRESENTATIVE_CHECK_TOP_ASSERT_SVH
`define ORBIT_MIN_REPRESENTATIVE_CHECK_TOP_ASSERT_SVH

// same-cycle implication
`define OMRC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("omrc assertion failed");

// next-cycle implication
`define OMRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("omrc assertion failed");

`endif

[design/omrc_pkg.sv]
// ----------------------------------------------------------------------------
// omrc_pkg
// Constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package omrc_pkg;

  localparam int MASK_BITS      = 32;
  localparam int MAX_TRANSFORMS = 64;

  localparam int SITE_W  = $clog2(MASK_BITS);
  localparam int XF_W    = $clog2(MAX_TRANSFORMS);
  localparam int NSITE_W = $clog2(MASK_BITS + 1);
  localparam int NXF_W   = $clog2(MAX_TRANSFORMS + 1);

  localparam int MODE_W  = 2;
  localparam int CODE_W  = 2;
  localparam int NT_W    = 7;
  localparam int NS_W    = 6;
  localparam int CFG_W   = 7;
  localparam int CIDX_W  = 2;

  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 8;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [MODE_W-1:0] MODE_SPIN    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HUBBARD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TJ      = 2'd2;

  localparam logic [CODE_W-1:0] REJ_NONE    = 2'd0;
  localparam logic [CODE_W-1:0] REJ_SMALLER = 2'd1;
  localparam logic [CODE_W-1:0] REJ_DOUBLE  = 2'd2;

  localparam logic [CIDX_W-1:0] REG_SYM_EN = 2'd0;
  localparam logic [CIDX_W-1:0] REG_MODE   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_NXF    = 2'd2;
  localparam logic [CIDX_W-1:0] REG_NSITES = 2'd3;

  typedef struct packed {
    logic            capture;
    logic            wr;
    logic            rd_en;
    logic [XF_W-1:0] rd_addr;
    logic            flush;
  } dp_cmd_t;

  typedef struct packed {
    logic valid;
    logic smaller;
    logic dbl;
  } dp_stat_t;

endpackage

[design/omrc_dpath.sv]
// ----------------------------------------------------------------------------
// omrc_dpath
// Permutation table banks, mask capture, image build and orbit compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module omrc_dpath (
  input  logic                             clk,
  input  logic                             rst,
  input  omrc_pkg::dp_cmd_t                cmd,
  input  logic [omrc_pkg::XF_W-1:0]        wr_xf,
  input  logic [omrc_pkg::SITE_W-1:0]      wr_site,
  input  logic [omrc_pkg::SITE_W-1:0]      wr_target,
  input  logic [omrc_pkg::MASK_BITS-1:0]   up_mask,
  input  logic [omrc_pkg::MASK_BITS-1:0]   down_mask,
  input  logic [omrc_pkg::NSITE_W-1:0]     n_sites,
  input  logic                             pair,
  output omrc_pkg::dp_stat_t               stat
);
  import omrc_pkg::*;

  // one bank per source site, addressed by transform
  logic [SITE_W-1:0]    perm_mem [MASK_BITS][MAX_TRANSFORMS];
  logic [SITE_W-1:0]    row [MASK_BITS];
  logic [MASK_BITS-1:0] site_m;
  logic [MASK_BITS-1:0] up_q;
  logic [MASK_BITS-1:0] dn_q;
  logic [MASK_BITS-1:0] img_up;
  logic [MASK_BITS-1:0] img_dn;
  logic [MASK_BITS-1:0] img_up_next;
  logic [MASK_BITS-1:0] img_dn_next;
  logic                 v1;
  logic                 v2;

  always_comb begin
    for (int i = 0; i < MASK_BITS; i++) begin
      site_m[i] = (NSITE_W'(i) < n_sites);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      perm_mem[wr_site][wr_xf] <= wr_target;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      for (int s = 0; s < MASK_BITS; s++) begin
        row[s] <= perm_mem[s][cmd.rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      up_q <= up_mask & site_m;
      dn_q <= pair ? (down_mask & site_m) : '0;
    end
  end

  // scatter: image bit d collects every occupied source mapped onto d
  always_comb begin
    for (int d = 0; d < MASK_BITS; d++) begin
      img_up_next[d] = 1'b0;
      img_dn_next[d] = 1'b0;
      for (int s = 0; s < MASK_BITS; s++) begin
        if (row[s] == SITE_W'(d)) begin
          img_up_next[d] = img_up_next[d] | up_q[s];
          img_dn_next[d] = img_dn_next[d] | dn_q[s];
        end
      end
      img_up_next[d] = img_up_next[d] & site_m[d];
      img_dn_next[d] = img_dn_next[d] & site_m[d];
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      img_up <= img_up_next;
      img_dn <= img_dn_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.flush) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
    end
  end

  // down mask is zero outside pair modes, so its term never fires there
  assign stat.valid   = v2;
  assign stat.smaller = (img_up < up_q) || ((img_up == up_q) && (img_dn < dn_q));
  assign stat.dbl     = |(up_q & dn_q);

endmodule

[design/omrc_ctrl.sv]
// ----------------------------------------------------------------------------
// omrc_ctrl
// Request sequencer: load/query dispatch, transform issue, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "orbit_min_representative_check_top_assert.svh"

module omrc_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           op,
  input  logic                           sym_en,
  input  logic                           tj,
  input  logic [omrc_pkg::NXF_W-1:0]     nt_used,
  input  omrc_pkg::dp_stat_t             stat,
  output omrc_pkg::dp_cmd_t              cmd,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_is_rep,
  output logic [omrc_pkg::CODE_W-1:0]    out_code
);
  import omrc_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_RUN, ST_HOLD} state_t;

  state_t             state;
  logic [NXF_W-1:0]   iss;
  logic [NXF_W-1:0]   ret;
  logic               pend_is_rep;
  logic [CODE_W-1:0]  pend_code;

  logic               accept;
  logic               can_push;
  logic               res_load;
  logic               fin;
  logic               fin_is_rep;
  logic [CODE_W-1:0]  fin_code;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign can_push = !out_valid || out_ready;
  assign res_load = can_push && (fin || (state == ST_HOLD));

  always_comb begin
    fin        = 1'b0;
    fin_is_rep = 1'b0;
    fin_code   = REJ_NONE;
    case (state)
      ST_IDLE: begin
        if (accept && (op == OP_LOAD)) begin
          fin = 1'b1;
        end else if (accept && !sym_en) begin
          fin        = 1'b1;
          fin_is_rep = 1'b1;
        end
      end
      ST_CHECK: begin
        if (tj && stat.dbl) begin
          fin      = 1'b1;
          fin_code = REJ_DOUBLE;
        end else if (nt_used == '0) begin
          fin        = 1'b1;
          fin_is_rep = 1'b1;
        end
      end
      ST_RUN: begin
        if (stat.valid && stat.smaller) begin
          fin      = 1'b1;
          fin_code = REJ_SMALLER;
        end else if (stat.valid && (ret == nt_used - NXF_W'(1))) begin
          fin        = 1'b1;
          fin_is_rep = 1'b1;
        end
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  assign cmd.capture = accept && (op == OP_QUERY) && sym_en;
  assign cmd.wr      = accept && (op == OP_LOAD);
  assign cmd.rd_en   = (state == ST_RUN) && (iss < nt_used) && !fin;
  assign cmd.rd_addr = iss[XF_W-1:0];
  assign cmd.flush   = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      iss       <= '0;
      ret       <= '0;
    end else begin
      if (out_valid && out_ready && !res_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE, ST_CHECK, ST_RUN: begin
          if (state == ST_RUN) begin
            if (cmd.rd_en) begin
              iss <= iss + NXF_W'(1);
            end
            if (stat.valid) begin
              ret <= ret + NXF_W'(1);
            end
          end
          if (fin) begin
            if (can_push) begin
              out_valid  <= 1'b1;
              out_is_rep <= fin_is_rep;
              out_code   <= fin_code;
              state      <= ST_IDLE;
            end else begin
              pend_is_rep <= fin_is_rep;
              pend_code   <= fin_code;
              state       <= ST_HOLD;
            end
          end else if (state == ST_IDLE && accept) begin
            state <= ST_CHECK;
          end else if (state == ST_CHECK) begin
            iss   <= '0;
            ret   <= '0;
            state <= ST_RUN;
          end
        end
        ST_HOLD: begin
          if (can_push) begin
            out_valid  <= 1'b1;
            out_is_rep <= pend_is_rep;
            out_code   <= pend_code;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `OMRC_ASSERT_IMPL(a_stat_in_run, stat.valid, state == ST_RUN)
  `OMRC_ASSERT_IMPL(a_hold_full, state == ST_HOLD, out_valid)
  `OMRC_ASSERT_IMPL(a_retire_order, state == ST_RUN, ret <= iss)
  `OMRC_ASSERT_NEXT(a_check_once, state == ST_CHECK, state != ST_CHECK)

endmodule

[design/orbit_min_representative_check_top.sv]
// Sequence: a load, or a query with symmetry off, goes from the idle state
// straight to the result register, or to the hold state while the output stalls;
// a query passes the check state and, unless it ends there, the run state, the table reading one transform row a cycle.
// Throughput: one request at a time; the next is taken while one result waits, not two.
// Reset: synchronous; config, state, counters and valid flags return to defaults;
// result, datapath data and table contents stay undefined until written.
// ----------------------------------------------------------------------------
// orbit_min_representative_check_top
// Orbit minimum representative check over a loaded site permutation table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module orbit_min_representative_check_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // transform_index[5:0], site_index[10:6], target_site[15:11],
  // up_mask[47:16], down_mask[79:48]
  input  logic [omrc_pkg::S_TDATA_W-1:0]    s_tdata,
  // op
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // is_rep[0], reject_code[2:1], zero[7:3]
  output logic [omrc_pkg::M_TDATA_W-1:0]    m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [omrc_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [omrc_pkg::CFG_W-1:0]        cfg_data
);
  import omrc_pkg::*;

  logic               sym_en;
  logic [MODE_W-1:0]  mode;
  logic [NT_W-1:0]    nxf;
  logic [NS_W-1:0]    nsites;

  logic [NXF_W-1:0]   nt_used;
  logic [NSITE_W-1:0] ns_used;
  logic               pair;
  logic               tj;

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic               res_is_rep;
  logic [CODE_W-1:0]  res_code;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_en <= 1'b1;
      mode   <= MODE_SPIN;
      nxf    <= NT_W'(1);
      nsites <= NS_W'(MASK_BITS);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SYM_EN: sym_en <= cfg_data[0];
        REG_MODE:   mode   <= cfg_data[MODE_W-1:0];
        REG_NXF:    nxf    <= cfg_data[NT_W-1:0];
        REG_NSITES: nsites <= cfg_data[NS_W-1:0];
        default:    sym_en <= sym_en;
      endcase
    end
  end

  assign nt_used = (nxf > NT_W'(MAX_TRANSFORMS)) ? NXF_W'(MAX_TRANSFORMS) : NXF_W'(nxf);
  assign ns_used = (nsites > NS_W'(MASK_BITS)) ? NSITE_W'(MASK_BITS) : NSITE_W'(nsites);
  assign pair    = (mode != MODE_SPIN);
  assign tj      = (mode == MODE_TJ);

  omrc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .op         (s_tuser),
    .sym_en     (sym_en),
    .tj         (tj),
    .nt_used    (nt_used),
    .stat       (stat),
    .cmd        (cmd),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_is_rep (res_is_rep),
    .out_code   (res_code)
  );

  omrc_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .wr_xf     (s_tdata[5:0]),
    .wr_site   (s_tdata[10:6]),
    .wr_target (s_tdata[15:11]),
    .up_mask   (s_tdata[47:16]),
    .down_mask (s_tdata[79:48]),
    .n_sites   (ns_used),
    .pair      (pair),
    .stat      (stat)
  );

  assign m_tdata = {5'b0, res_code, res_is_rep};

endmodule
